// File: src/rag_pkg.sv
package rag_pkg;

  // Legal maxima of the walked tensor
  localparam int unsigned MAX_BATCH    = 16;
  localparam int unsigned MAX_CHANNELS = 1024;
  localparam int unsigned MAX_DIM      = 1024;

  // Register and counter widths
  localparam int unsigned NB_W    = 5;   // batches register
  localparam int unsigned DIMR_W  = 11;  // channels, height, width registers
  localparam int unsigned CFG_W   = 11;  // widest register
  localparam int unsigned IDX_W   = 3;   // register index
  localparam int unsigned BCNT_W  = 4;   // batch counter
  localparam int unsigned CNT_W   = 10;  // channel, row and column counters
  localparam int unsigned OC_W    = 9;   // channels / 4, 1..256
  localparam int unsigned SUB_W   = 8;   // channel remainder
  localparam int unsigned H2_W    = 12;
  localparam int unsigned W2_W    = 11;
  localparam int unsigned MUL_A_W = 12;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned ACC_W   = 36;

  // Sequencer lengths
  localparam int unsigned DIV_STEPS = CNT_W;
  localparam int unsigned MUL_STEPS = 6;
  localparam int unsigned STEP_W    = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_LIN_C,
    MUL_LIN_H,
    MUL_LIN_W,
    MUL_REO_C,
    MUL_REO_H,
    MUL_REO_W
  } mul_op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_BATCHES,
    REG_CHANNELS,
    REG_HEIGHT,
    REG_WIDTH,
    REG_DIRECTION
  } reg_idx_e;

  // Clamped tensor shape as seen by the datapath
  typedef struct packed {
    logic [NB_W-1:0]   nb;
    logic [DIMR_W-1:0] nc;
    logic [DIMR_W-1:0] nh;
    logic [DIMR_W-1:0] nw;
    logic [OC_W-1:0]   oc;
    logic              direction;
  } rag_cfg_t;

  typedef struct packed {
    logic    start;
    logic    div_step;
    logic    mul_en;
    mul_op_e mul_op;
    logic    finish;
  } rag_cmd_t;

  typedef struct packed {
    logic out_busy;
  } rag_sts_t;

endpackage

// File: src/rag_ctrl.sv
module rag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rag_pkg::rag_sts_t sts_i,
  output rag_pkg::rag_cmd_t cmd_o
);
  import rag_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_MUL: begin
        if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.mul_op    = mul_op_e'(cnt_q[2:0]);
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_MUL:  cmd_o.mul_en   = 1'b1;
      ST_DONE: cmd_o.finish   = !sts_i.out_busy;
      default: in_ready_o     = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DIV)
    else $error("accepted transfer did not start the divider");

  a_finish_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_busy)
    else $error("result loaded over a stalled output");

  a_mul_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> cnt_q < STEP_W'(MUL_STEPS))
    else $error("multiply step out of range");

endmodule

// File: src/rag_dp.sv
module rag_dp #(
  parameter int unsigned ADDR_BITS = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rag_pkg::rag_cfg_t    cfg_i,
  input  rag_pkg::rag_cmd_t    cmd_i,
  input  logic                 restart_i,
  input  logic                 out_ready_i,
  output rag_pkg::rag_sts_t    sts_o,
  output logic                 out_valid_o,
  output logic [ADDR_BITS-1:0] rd_addr_o,
  output logic [ADDR_BITS-1:0] wr_addr_o,
  output logic                 last_o
);
  import rag_pkg::*;

  // Walk position
  logic [BCNT_W-1:0] batch_q, batch_d;
  logic [CNT_W-1:0]  chan_q, chan_d, row_q, row_d, col_q, col_d;

  // Channel divider: remainder and dividend/quotient shift register
  logic [SUB_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  quo_q, quo_d;
  logic [SUB_W:0]    div_shift;
  logic              div_ge;

  // Shared multiply-add
  logic [ACC_W-1:0]   lin_q, lin_d, reo_q, reo_d, mac;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [H2_W-1:0]    addend, h2;
  logic [W2_W-1:0]    w2;

  logic end_w, end_h, end_c, end_b, last_d;

  logic                 out_valid_q;
  logic [ADDR_BITS-1:0] rd_q, wr_q;
  logic                 last_q;

  // Walk ends; a counter at or past a shrunk limit counts as the final one
  always_comb begin
    end_w  = ({1'b0, col_q}  + DIMR_W'(1)) >= cfg_i.nw;
    end_h  = ({1'b0, row_q}  + DIMR_W'(1)) >= cfg_i.nh;
    end_c  = ({1'b0, chan_q} + DIMR_W'(1)) >= cfg_i.nc;
    end_b  = ({1'b0, batch_q} + NB_W'(1))  >= cfg_i.nb;
    last_d = end_w && end_h && end_c && end_b;
  end

  always_comb begin
    batch_d = batch_q;
    chan_d  = chan_q;
    row_d   = row_q;
    col_d   = col_q;
    if (cmd_i.start && restart_i) begin
      batch_d = '0;
      chan_d  = '0;
      row_d   = '0;
      col_d   = '0;
    end else if (cmd_i.finish) begin
      if (!end_w) begin
        col_d = col_q + CNT_W'(1);
      end else begin
        col_d = '0;
        if (!end_h) begin
          row_d = row_q + CNT_W'(1);
        end else begin
          row_d = '0;
          if (!end_c) begin
            chan_d = chan_q + CNT_W'(1);
          end else begin
            chan_d  = '0;
            batch_d = end_b ? '0 : batch_q + BCNT_W'(1);
          end
        end
      end
    end
  end

  // Restoring division of the channel by channels/4, one bit per step
  always_comb begin
    div_shift = {rem_q, quo_q[CNT_W-1]};
    div_ge    = div_shift >= cfg_i.oc;
    rem_d     = rem_q;
    quo_d     = quo_q;
    if (cmd_i.start) begin
      rem_d = '0;
      quo_d = restart_i ? '0 : chan_q;
    end else if (cmd_i.div_step) begin
      rem_d = div_ge ? SUB_W'(div_shift - cfg_i.oc) : SUB_W'(div_shift);
      quo_d = {quo_q[CNT_W-2:0], div_ge};
    end
  end

  // Reorganized coordinates from the phase (quotient)
  assign h2 = H2_W'({row_q, 1'b0}) + H2_W'(quo_q[CNT_W-1:1]);
  assign w2 = {col_q, quo_q[0]};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    case (cmd_i.mul_op)
      MUL_LIN_C: begin
        mul_a  = MUL_A_W'(cfg_i.nc);
        mul_b  = MUL_B_W'(batch_q);
        addend = H2_W'(chan_q);
      end
      MUL_LIN_H: begin
        mul_a  = MUL_A_W'(cfg_i.nh);
        mul_b  = lin_q[MUL_B_W-1:0];
        addend = H2_W'(row_q);
      end
      MUL_LIN_W: begin
        mul_a  = MUL_A_W'(cfg_i.nw);
        mul_b  = lin_q[MUL_B_W-1:0];
        addend = H2_W'(col_q);
      end
      MUL_REO_C: begin
        mul_a  = MUL_A_W'(cfg_i.oc);
        mul_b  = MUL_B_W'(batch_q);
        addend = H2_W'(rem_q);
      end
      MUL_REO_H: begin
        mul_a  = {cfg_i.nh, 1'b0};
        mul_b  = reo_q[MUL_B_W-1:0];
        addend = h2;
      end
      MUL_REO_W: begin
        mul_a  = {cfg_i.nw, 1'b0};
        mul_b  = reo_q[MUL_B_W-1:0];
        addend = H2_W'(w2);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        addend = '0;
      end
    endcase
    mac = ACC_W'(mul_a) * ACC_W'(mul_b) + ACC_W'(addend);
  end

  always_comb begin
    lin_d = lin_q;
    reo_d = reo_q;
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        MUL_LIN_C, MUL_LIN_H, MUL_LIN_W: lin_d = mac;
        MUL_REO_C, MUL_REO_H, MUL_REO_W: reo_d = mac;
        default: lin_d = lin_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q     <= '0;
      chan_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      batch_q <= batch_d;
      chan_q  <= chan_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    lin_q <= lin_d;
    reo_q <= reo_d;
    if (cmd_i.finish) begin
      rd_q   <= cfg_i.direction ? ADDR_BITS'(lin_q) : ADDR_BITS'(reo_q);
      wr_q   <= cfg_i.direction ? ADDR_BITS'(reo_q) : ADDR_BITS'(lin_q);
      last_q <= last_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign rd_addr_o      = rd_q;
  assign wr_addr_o      = wr_q;
  assign last_o         = last_q;

  a_finish_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished item did not reach the output register");

  a_restart_clears_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && restart_i |=>
      batch_q == '0 && chan_q == '0 && row_q == '0 && col_q == '0)
    else $error("restart did not return the walk to the first element");

  a_last_wraps_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && last_d |=>
      batch_q == '0 && chan_q == '0 && row_q == '0 && col_q == '0)
    else $error("walk did not wrap after the final element");

endmodule

// File: src/reorg_address_generator.sv
// Reorg address generator: walks a batch x channel x height x width tensor in
// batch, channel, row, column order and gives, for each element, the linear
// index and the space-to-depth reorganized index as a read/write address pair.
//
// Channels:
//   s_axis  - one transfer per element; bit 0 of tdata is restart, which
//             returns the walk to the first element before the pair is formed.
//   m_axis  - one transfer per element carrying read and write address;
//             tlast marks the final element of the tensor, after which the
//             walk wraps to the first element.
//   cfg     - register writes (batches, channels, height, width, direction),
//             taken at any edge with cfg_we_i high; issue them only while idle.
//             Direction 0 reads at the reorganized index, 1 writes there.
// Sequence: each element is accepted, runs through the bit-serial channel
//   divider (channel / (channels/4)), then through the shared multiply-add
//   unit forming both indices, and finally loads the result register, from
//   which it is offered on m_axis.
// Reset: shape returns to 1 x 4 x 1 x 1, forward direction, walk at element 0.
// Stall: the result register holds while m_axis_tready is low; the next
//   element is accepted and worked on meanwhile, and waits at its end.
module reorg_address_generator #(
  parameter int unsigned ADDR_BITS = 34
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Configuration write port
  input  logic                                         cfg_we_i,
  input  logic [rag_pkg::IDX_W-1:0]                    cfg_index_i,
  input  logic [rag_pkg::CFG_W-1:0]                    cfg_data_i,
  // Element requests; tdata: [0] restart
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  logic [7:0]                                   s_axis_tdata,
  // Address pairs; tdata: read_address, then write_address, zero padded
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  output logic [((2*ADDR_BITS+7)/8)*8-1:0]             m_axis_tdata,
  output logic                                         m_axis_tlast
);
  import rag_pkg::*;

  localparam int unsigned TDATA_W = ((2 * ADDR_BITS + 7) / 8) * 8;

  logic [NB_W-1:0]   batches_q;
  logic [DIMR_W-1:0] channels_q, height_q, width_q;
  logic              direction_q;

  rag_cfg_t cfg;
  rag_cmd_t cmd;
  rag_sts_t sts;

  logic [ADDR_BITS-1:0] rd_addr, wr_addr;

  // Register file; writes to unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batches_q   <= NB_W'(1);
      channels_q  <= DIMR_W'(4);
      height_q    <= DIMR_W'(1);
      width_q     <= DIMR_W'(1);
      direction_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BATCHES:   batches_q   <= cfg_data_i[NB_W-1:0];
        REG_CHANNELS:  channels_q  <= cfg_data_i[DIMR_W-1:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[DIMR_W-1:0];
        REG_WIDTH:     width_q     <= cfg_data_i[DIMR_W-1:0];
        REG_DIRECTION: direction_q <= cfg_data_i[0];
        default:       direction_q <= direction_q;
      endcase
    end
  end

  // Clamp the shape: zero counts as one, oversize saturates to the maximum
  always_comb begin
    cfg.nb = (batches_q == '0) ? NB_W'(1) :
             (batches_q > NB_W'(MAX_BATCH)) ? NB_W'(MAX_BATCH) : batches_q;
    cfg.nc = (channels_q == '0) ? DIMR_W'(1) :
             (channels_q > DIMR_W'(MAX_CHANNELS)) ? DIMR_W'(MAX_CHANNELS) : channels_q;
    cfg.nh = (height_q == '0) ? DIMR_W'(1) :
             (height_q > DIMR_W'(MAX_DIM)) ? DIMR_W'(MAX_DIM) : height_q;
    cfg.nw = (width_q == '0) ? DIMR_W'(1) :
             (width_q > DIMR_W'(MAX_DIM)) ? DIMR_W'(MAX_DIM) : width_q;
    // Channel group size, never below one
    cfg.oc = (cfg.nc[DIMR_W-1:2] == '0) ? OC_W'(1) : OC_W'(cfg.nc[DIMR_W-1:2]);
    cfg.direction = direction_q;
  end

  rag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rag_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .restart_i   (s_axis_tdata[0]),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'({wr_addr, rd_addr});

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer accepted while an element is in work");

  a_result_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("stalled result dropped");

  a_oc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> cfg.oc != '0)
    else $error("channel group size is zero");

endmodule

// File: bench/reorg_address_generator_checker.sv
module reorg_address_generator_checker #(
  parameter int unsigned ADDR_BITS = 34
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rag_pkg::IDX_W-1:0]             cfg_index_i,
  input  logic [rag_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,   // [0] restart
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // read_address, write_address, zero padding
  input  logic [((2*ADDR_BITS+7)/8)*8-1:0]      m_axis_tdata,
  input  logic                                  m_axis_tlast,
  output int                                    mismatches_o,
  output int                                    pending_o,
  output int                                    tensor_ends_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rag_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 is_last;
  } addr_pair_t;

  // Shadow of the shape registers
  logic [NB_W-1:0]   batches_q;
  logic [DIMR_W-1:0] channels_q;
  logic [DIMR_W-1:0] height_q;
  logic [DIMR_W-1:0] width_q;
  logic              backward_q;

  // Walk position
  logic [BCNT_W-1:0] batch_q;
  logic [CNT_W-1:0]  chan_q;
  logic [CNT_W-1:0]  row_q;
  logic [CNT_W-1:0]  col_q;

  addr_pair_t pending_pairs[$];

  initial begin
    mismatches_o  = 0;
    pending_o     = 0;
    tensor_ends_o = 0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Form the address pair of the current element, then advance the walk
  task automatic walk_element(input logic restart, output addr_pair_t pair);
    int unsigned nb, nc, nh, nw, oc, sub, off;
    logic [63:0] lin, reo, w2, h2;
    logic        end_w, end_h, end_c, end_b;
    nb = clamp_dim(batches_q, MAX_BATCH);
    nc = clamp_dim(channels_q, MAX_CHANNELS);
    nh = clamp_dim(height_q, MAX_DIM);
    nw = clamp_dim(width_q, MAX_DIM);
    oc = nc / 4;
    if (oc == 0) oc = 1;
    if (restart) begin
      batch_q = '0;
      chan_q  = '0;
      row_q   = '0;
      col_q   = '0;
    end
    sub = 32'(chan_q) % oc;
    off = 32'(chan_q) / oc;
    lin = 64'(col_q) + 64'(nw) * (64'(row_q) + 64'(nh) * (64'(chan_q) + 64'(nc) * 64'(batch_q)));
    // Space-to-depth index, without channel scaling in the outer term
    w2  = 2 * 64'(col_q) + 64'(off % 2);
    h2  = 2 * 64'(row_q) + 64'(off / 2);
    reo = w2 + 2 * 64'(nw) * (h2 + 2 * 64'(nh) * (64'(sub) + 64'(oc) * 64'(batch_q)));
    // A counter at or beyond a shrunk limit counts as final at its level
    end_w = 32'(col_q) + 1 >= nw;
    end_h = 32'(row_q) + 1 >= nh;
    end_c = 32'(chan_q) + 1 >= nc;
    end_b = 32'(batch_q) + 1 >= nb;
    pair.is_last = end_w && end_h && end_c && end_b;
    if (backward_q) begin
      pair.rd_addr = lin[ADDR_BITS-1:0];
      pair.wr_addr = reo[ADDR_BITS-1:0];
    end else begin
      pair.rd_addr = reo[ADDR_BITS-1:0];
      pair.wr_addr = lin[ADDR_BITS-1:0];
    end
    if (!end_w) begin
      col_q = col_q + 1'b1;
    end else begin
      col_q = '0;
      if (!end_h) begin
        row_q = row_q + 1'b1;
      end else begin
        row_q = '0;
        if (!end_c) begin
          chan_q = chan_q + 1'b1;
        end else begin
          chan_q  = '0;
          batch_q = end_b ? '0 : batch_q + 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    addr_pair_t got, want;
    logic       pad_ok;
    if (!rst_ni) begin
      batches_q  = NB_W'(1);
      channels_q = DIMR_W'(4);
      height_q   = DIMR_W'(1);
      width_q    = DIMR_W'(1);
      backward_q = 1'b0;
      batch_q    = '0;
      chan_q     = '0;
      row_q      = '0;
      col_q      = '0;
      pending_pairs.delete();
    end else begin
      // Retire the oldest expectation first: a pair accepted in this cycle
      // is far too young to leave the block in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        got.rd_addr = m_axis_tdata[ADDR_BITS-1:0];
        got.wr_addr = m_axis_tdata[2*ADDR_BITS-1:ADDR_BITS];
        got.is_last = m_axis_tlast;
        pad_ok      = (m_axis_tdata >> (2*ADDR_BITS)) == '0;
        if (got.is_last) tensor_ends_o++;
        if (pending_pairs.size() == 0) begin
          if (mismatches_o < REPORT_LIMIT)
            $display("%0t: address pair with no request waiting: rd %h wr %h last %b",
                     $realtime, got.rd_addr, got.wr_addr, got.is_last);
          mismatches_o++;
        end else begin
          want = pending_pairs.pop_front();
          if (got.rd_addr != want.rd_addr || got.wr_addr != want.wr_addr ||
              got.is_last != want.is_last || !pad_ok) begin
            if (mismatches_o < REPORT_LIMIT)
              $display("%0t: pair mismatch: rd %h/%h wr %h/%h last %b/%b pad %s (want/got)",
                       $realtime, want.rd_addr, got.rd_addr, want.wr_addr, got.wr_addr,
                       want.is_last, got.is_last, pad_ok ? "zero" : "dirty");
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_BATCHES:   batches_q  = cfg_data_i[NB_W-1:0];
          REG_CHANNELS:  channels_q = cfg_data_i[DIMR_W-1:0];
          REG_HEIGHT:    height_q   = cfg_data_i[DIMR_W-1:0];
          REG_WIDTH:     width_q    = cfg_data_i[DIMR_W-1:0];
          REG_DIRECTION: backward_q = cfg_data_i[0];
          default: ;  // spare index: drop the write
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        walk_element(s_axis_tdata[0], want);
        pending_pairs.push_back(want);
      end
    end
    pending_o = pending_pairs.size();
  end

endmodule

// File: bench/reorg_address_generator_tb.sv
module reorg_address_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rag_pkg::*;

  localparam int unsigned ADDR_BITS   = 34;
  localparam int unsigned TDATA_W     = ((2*ADDR_BITS+7)/8)*8;
  localparam int unsigned NUM_REGS    = int'(REG_DIRECTION) + 1;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned MAX_GAP     = 12;
  // Pause after the last pair comes back; longer than an element spends inside the block
  localparam int unsigned SETTLE_CYCLES = 24;
  // Longest quiet stretch of a correct run is a sender gap, the element
  // latency, a receiver stall and a settle pause: well below this limit
  localparam int unsigned STALL_LIMIT = 1000;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;   // [0] restart
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;         // read_address, write_address, padding
  logic               m_axis_tlast;

  int mismatches;
  int pending;
  int tensor_ends;

  // Register plan for the next idle window; pick says which ones go out
  int unsigned       cfg_plan [NUM_REGS];
  logic [NUM_REGS-1:0] cfg_pick;

  // Per-phase idling mode of each side: steady means no gaps at all
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  int items_sent    = 0;
  int restarts_sent = 0;
  int settings      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  reorg_address_generator #(.ADDR_BITS(ADDR_BITS)) i_dut (.*);

  reorg_address_generator_checker #(.ADDR_BITS(ADDR_BITS)) i_checker (
    .*,
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .tensor_ends_o(tensor_ends)
  );

  // Offer one element request and hold it until the transfer happens
  task automatic send_item(input logic restart);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (restart) restarts_sent++;
    @(negedge clk_i);
  endtask

  // Run a burst of elements; restart on the first one and/or now and then
  task automatic run_phase(input int unsigned n, input bit restart_first, input bit restart_rnd);
    logic restart;
    for (int k = 0; k < n; k++) begin
      restart = (k == 0 && restart_first) || (restart_rnd && $urandom_range(0, 15) == 0);
      send_item(restart);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every address pair has come back and the block has gone quiet
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the picked registers back to back, optionally one spare index too
  task automatic program_regs(input bit spare);
    for (int r = 0; r < NUM_REGS; r++) begin
      if (cfg_pick[r]) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= IDX_W'(r);
        cfg_data_i  <= CFG_W'(cfg_plan[r]);
        @(negedge clk_i);
      end
    end
    if (spare) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1));
      cfg_data_i  <= CFG_W'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic set_shape(input int unsigned nb, input int unsigned nc, input int unsigned nh,
                           input int unsigned nw, input bit backward, input bit spare);
    cfg_plan[REG_BATCHES]   = nb;
    cfg_plan[REG_CHANNELS]  = nc;
    cfg_plan[REG_HEIGHT]    = nh;
    cfg_plan[REG_WIDTH]     = nw;
    cfg_plan[REG_DIRECTION] = backward;
    cfg_pick = '1;
    program_regs(spare);
  endtask

  // Mostly small shapes so the walk wraps often; now and then zero, the
  // legal maximum, the all-ones value or anything at all
  function automatic int unsigned pick_size(input int unsigned bits, input int unsigned maxv,
                                            input int unsigned common);
    int unsigned draw;
    draw = $urandom_range(0, 15);
    if (draw == 0) return 0;
    if (draw == 1) return maxv;
    if (draw == 2) return (1 << bits) - 1;
    if (draw == 3) return $urandom_range(0, (1 << bits) - 1);
    return $urandom_range(1, common);
  endfunction

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset shape 1 x 4 x 1 x 1: every fourth element ends the tensor;
    // restart mid-walk
    run_phase(2, 1'b0, 1'b0);
    run_phase(3, 1'b1, 1'b0);
    settle();

    // Channels not a multiple of four, backward direction
    set_shape(2, 6, 2, 3, 1'b1, 1'b0);
    run_phase(5, 1'b0, 1'b0);
    settle();
    // Shrink width and height under the walk: the counters sit beyond the
    // new limits and must wrap on the next advance
    cfg_plan[REG_HEIGHT] = 1;
    cfg_plan[REG_WIDTH]  = 1;
    cfg_pick = '0;
    cfg_pick[REG_HEIGHT] = 1'b1;
    cfg_pick[REG_WIDTH]  = 1'b1;
    program_regs(1'b0);
    run_phase(2, 1'b0, 1'b0);
    settle();

    // Zero everywhere: dimensions read as one, channels below four
    set_shape(0, 0, 0, 0, 1'b0, 1'b0);
    run_phase(3, 1'b0, 1'b0);
    settle();

    // All-ones values saturate to the maxima
    set_shape((1 << NB_W) - 1, (1 << DIMR_W) - 1, (1 << DIMR_W) - 1, (1 << DIMR_W) - 1,
              1'b0, 1'b0);
    run_phase(3, 1'b1, 1'b0);
    settle();

    // Legal maxima, backward, plus a write to a spare index that must be dropped
    set_shape(MAX_BATCH, MAX_CHANNELS, MAX_DIM, MAX_DIM, 1'b1, 1'b1);
    run_phase(3, 1'b0, 1'b0);
    settle();

    set_shape(1, 4, 1, 1, 1'b0, 1'b0);
    run_phase(4, 1'b1, 1'b0);

    // Random phases: new settings on an idle block, then a burst of elements,
    // mostly without restart so that shrinking and growing hit a live walk
    while (items_sent < ITEM_TARGET) begin
      settle();
      cfg_plan[REG_BATCHES]   = pick_size(NB_W, MAX_BATCH, 2);
      cfg_plan[REG_CHANNELS]  = pick_size(DIMR_W, MAX_CHANNELS, 8);
      cfg_plan[REG_HEIGHT]    = pick_size(DIMR_W, MAX_DIM, 3);
      cfg_plan[REG_WIDTH]     = pick_size(DIMR_W, MAX_DIM, 3);
      cfg_plan[REG_DIRECTION] = $urandom_range(0, 1);
      cfg_pick = NUM_REGS'($urandom);
      program_regs($urandom_range(0, 5) == 0);
      tx_steady = $urandom_range(0, 3) == 0;
      rx_steady = $urandom_range(0, 3) == 0;
      run_phase($urandom_range(4, 40), $urandom_range(0, 3) == 0, 1'b1);
    end

    settle();
    $display("Walked %0d elements (%0d restarts) under %0d register settings, %0d tensor ends.",
             items_sent, restarts_sent, settings, tensor_ends);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d address pair failures", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles ahead of each pair, none when rx_steady
  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Abort when no transfer and no register write happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d pairs outstanding", STALL_LIMIT, pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
src/rag_pkg.sv
src/rag_ctrl.sv
src/rag_dp.sv
src/reorg_address_generator.sv
bench/reorg_address_generator_checker.sv
bench/reorg_address_generator_tb.sv
